### hw/rtl/hsvba_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the hsv brightness block
package hsvba_pkg;

	localparam int unsigned ONE_Q16   = 65536;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam logic [9:0]  BRIGHT_RESET = 10'd100;

	typedef enum logic [0:0] {
		REG_BRIGHTNESS = 1'b0,
		REG_GREYSCALE  = 1'b1
	} reg_idx_t;

	// item handed from front to back
	typedef struct packed {
		logic        pass;      // output rgb already final
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic        fe;
		logic [2:0]  sector;    // 0..5
		logic [7:0]  num;       // hue numerator distance
		logic        neg;       // fraction subtracted from sector base
		logic [7:0]  d;
		logic [7:0]  mx;
	} task_t;

endpackage

### hw/rtl/hsv_pixel_brightness_adjust.sv
`timescale 1ns / 1ps
// top level: rgb pixel brightness adjust through hsv
//  channel | signals                                   | dir
//  in      | valid ready red_in green_in blue_in frame_end | in
//  out     | out_valid out_ready red_out green_out blue_out frame_end_out | out
//  cfg     | cfg_we cfg_idx cfg_data                   | in
// one pixel per clock sustained while out_ready stays high; the path runs through the 24-stage
// hue/saturation divider pipeline plus math and output stages.
// asynchronous reset restores brightness 100 and color mode.
// output stall halts the back pipe; the front keeps filling a 4-entry queue.
module hsv_pixel_brightness_adjust
	import hsvba_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       ready,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic       frame_end_out,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [9:0] cfg_data
);
	logic [9:0] bright_q;
	logic grey_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHT_RESET;
			grey_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_BRIGHTNESS: bright_q <= cfg_data;
				REG_GREYSCALE:  grey_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic f_v, f_r, q_v, q_r;
	task_t f_d, q_d;

	hsvba_front u_front (
		.clk, .arst_n, .valid, .ready, .red_in, .green_in, .blue_in, .frame_end,
		.grey_en(grey_q), .tvalid(f_v), .tready(f_r), .tdata(f_d));

	hsvba_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk, .arst_n, .in_valid(f_v), .in_ready(f_r), .in_data(f_d),
		.out_valid(q_v), .out_ready(q_r), .out_data(q_d));

	hsvba_back u_back (
		.clk, .arst_n, .bright(bright_q), .tvalid(q_v), .tready(q_r), .tdata(q_d),
		.valid(out_valid), .ready(out_ready), .red_out, .green_out, .blue_out,
		.frame_end_out);
endmodule

### hw/rtl/hsvba_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
module hsvba_div
	import hsvba_pkg::*;
#(
	parameter int unsigned NUM_W = 24,
	parameter int unsigned DEN_W = 8,
	parameter int unsigned TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag,
	output logic [NUM_W-1:0] quo,
	output logic [TAG_W-1:0] tag_out
);
	logic [NUM_W-1:0] n_q   [NUM_W+1];
	logic [DEN_W:0]   rem_q [NUM_W+1];
	logic [DEN_W-1:0] den_q [NUM_W+1];
	logic [TAG_W-1:0] tag_q [NUM_W+1];

	always_comb begin
		n_q[0]   = num;
		rem_q[0] = '0;
		den_q[0] = den;
		tag_q[0] = tag;
	end

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W+1:0] sh;
		logic [DEN_W+1:0] diff;
		assign sh   = {rem_q[i], n_q[i][NUM_W-1]};
		assign diff = sh - {2'b00, den_q[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				den_q[i+1] <= den_q[i];
				tag_q[i+1] <= tag_q[i];
				if (!diff[DEN_W+1]) begin
					rem_q[i+1] <= diff[DEN_W:0];
					n_q[i+1]   <= {n_q[i][NUM_W-2:0], 1'b1};
				end else begin
					rem_q[i+1] <= sh[DEN_W:0];
					n_q[i+1]   <= {n_q[i][NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo     = n_q[NUM_W];
	assign tag_out = tag_q[NUM_W];

	logic unused;
	assign unused = arst_n;
endmodule

### hw/rtl/hsvba_front.sv
`timescale 1ns / 1ps
// front: registers the pixel, handles grey modes and classifies hue sector
module hsvba_front
	import hsvba_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       ready,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic       frame_end,
	input  logic       grey_en,
	output logic       tvalid,
	input  logic       tready,
	output task_t      tdata
);
	task_t t_c;
	logic [7:0] mx, mn;
	logic [12:0] y;
	logic valid_q;
	task_t data_q;

	always_comb begin
		t_c = '0;
		mx = red_in; mn = red_in;
		if (green_in > mx) mx = green_in;
		if (blue_in > mx)  mx = blue_in;
		if (green_in < mn) mn = green_in;
		if (blue_in < mn)  mn = blue_in;
		y = 13'(red_in) * 13'd11 + {1'b0, green_in, 4'b0} + 13'(blue_in) * 13'd5;
		t_c.fe = frame_end;
		t_c.mx = mx;
		t_c.d  = mx - mn;
		t_c.r = red_in; t_c.g = green_in; t_c.b = blue_in;
		if (grey_en) begin
			t_c.pass = 1'b1;
			t_c.r = y[12:5]; t_c.g = y[12:5]; t_c.b = y[12:5];
		end else if (mx == mn) begin
			t_c.pass = 1'b1;
		end else if (red_in == mx) begin
			if (green_in == mn) begin
				t_c.sector = 3'd5; t_c.num = mx - blue_in; t_c.neg = 1'b0;
			end else begin
				t_c.sector = 3'd1; t_c.num = mx - green_in; t_c.neg = 1'b1;
			end
		end else if (green_in == mx) begin
			if (blue_in == mn) begin
				t_c.sector = 3'd1; t_c.num = mx - red_in; t_c.neg = 1'b0;
			end else begin
				t_c.sector = 3'd3; t_c.num = mx - blue_in; t_c.neg = 1'b1;
			end
		end else begin
			if (red_in == mn) begin
				t_c.sector = 3'd3; t_c.num = mx - green_in; t_c.neg = 1'b0;
			end else begin
				t_c.sector = 3'd5; t_c.num = mx - red_in; t_c.neg = 1'b1;
			end
		end
	end

	assign ready = !valid_q || tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) data_q <= t_c;
	end

	assign tvalid = valid_q;
	assign tdata  = data_q;
endmodule

### hw/rtl/hsvba_fifo.sv
`timescale 1ns / 1ps
// short queue between front and back
module hsvba_fifo
	import hsvba_pkg::*;
#(
	parameter int unsigned DEPTH = FIFO_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  task_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output task_t out_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	task_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready  = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;
	assign out_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end
endmodule

### hw/rtl/hsvba_back.sv
`timescale 1ns / 1ps
// back: hsv math pipeline with stall-all enable and output register
module hsvba_back
	import hsvba_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [9:0] bright,
	input  logic       tvalid,
	output logic       tready,
	input  task_t      tdata,
	output logic       valid,
	input  logic       ready,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic       frame_end_out
);
	localparam int unsigned DLAT = 24;
	localparam int unsigned TW = $bits(task_t) + 1;

	// advance whole pipe when output slot frees
	logic en;
	logic out_v_q;
	logic [DLAT-1:0] v_div;
	logic v_s1, v_s2, v_s3, v_s4;
	assign en = !out_v_q || ready;
	assign tready = en;

	// two dividers in parallel: hue term, saturation
	logic [23:0] hq, sq;
	logic [TW-1:0] tag_o;
	task_t td;
	logic [23:0] hnum, snum;
	assign hnum = {tdata.num, 16'b0};
	assign snum = {tdata.d, 16'b0};

	hsvba_div #(.NUM_W(24), .DEN_W(8), .TAG_W(TW)) u_hdiv (
		.clk, .arst_n, .en, .num(hnum), .den(tdata.d),
		.tag({tdata, tvalid && !tdata.pass}), .quo(hq), .tag_out(tag_o));
	hsvba_div #(.NUM_W(24), .DEN_W(8), .TAG_W(1)) u_sdiv (
		.clk, .arst_n, .en, .num(snum), .den(tdata.pass ? 8'd1 : tdata.mx),
		.tag(1'b0), .quo(sq), .tag_out());
	assign td = tag_o[TW-1:1];

	// value as q16: ceil(mx * 65536 / 255) = 257 * mx + (mx != 0)
	logic [16:0] v_c;
	assign v_c = {1'b0, td.mx, 8'b0} + {9'b0, td.mx} + {16'b0, |td.mx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_div <= '0;
		else if (en) v_div <= {v_div[DLAT-2:0], tvalid};
	end

	// s1: hue, v*bright
	logic [18:0] h_s1;
	logic [16:0] s_s1, f_s1;
	logic [26:0] vbx_s1;
	task_t t_s1;
	logic [18:0] base;
	always_comb base = {td.sector, 16'b0};
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= td;
			s_s1 <= sq[16:0];
			vbx_s1 <= v_c * bright;
			h_s1 <= td.neg ? base - {2'b0, hq[16:0]} : base + {2'b0, hq[16:0]};
		end
	end

	// s2: vb clamp/div100, sf products
	logic [16:0] vb_s2, s_s2;
	logic [2:0] sec_s2;
	logic [33:0] sf_s2, sfn_s2;
	task_t t_s2;
	logic [53:0] vb_prod;
	logic [20:0] vb_div;
	logic [16:0] f1;
	logic [17:0] fn;
	// floor(x / 100) as x * ceil(2^33 / 100) >> 33, exact for x below 2^30
	assign vb_prod = vbx_s1 * 27'd85899346;
	assign vb_div = vb_prod[53:33];
	assign f1 = {1'b0, h_s1[15:0]};
	assign fn = 18'(ONE_Q16) - {2'b0, h_s1[15:0]};
	always_ff @(posedge clk) begin
		if (en) begin
			t_s2 <= t_s1;
			s_s2 <= s_s1;
			vb_s2 <= (vb_div > 21'(ONE_Q16)) ? 17'(ONE_Q16) : vb_div[16:0];
			sec_s2 <= (h_s1[18:16] == 3'd6) ? 3'd0 : h_s1[18:16];
			sf_s2 <= s_s1 * f1;
			sfn_s2 <= s_s1 * fn[16:0];
		end
	end

	// s3: p,q,t products
	logic [33:0] p_s3, q_s3, tt_s3;
	logic [16:0] vb_s3;
	logic [2:0] sec_s3;
	task_t t_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			t_s3 <= t_s2; vb_s3 <= vb_s2; sec_s3 <= sec_s2;
			p_s3  <= vb_s2 * (17'(ONE_Q16) - s_s2);
			q_s3  <= vb_s2 * (17'(ONE_Q16) - sf_s2[32:16]);
			tt_s3 <= vb_s2 * (17'(ONE_Q16) - sfn_s2[32:16]);
		end
	end

	function automatic logic [7:0] to_code(input logic [16:0] x);
		logic [24:0] m;
		m = {x, 8'b0} - {8'b0, x};
		return m[23:16];
	endfunction

	logic [7:0] pc, qc, tc, vc;
	assign pc = to_code(p_s3[32:16]);
	assign qc = to_code(q_s3[32:16]);
	assign tc = to_code(tt_s3[32:16]);
	assign vc = to_code(vb_s3);

	logic [7:0] r_q, g_q, b_q;
	logic fe_q;
	always_ff @(posedge clk) begin
		if (en && v_s3) begin
			fe_q <= t_s3.fe;
			if (t_s3.pass) begin
				r_q <= t_s3.r; g_q <= t_s3.g; b_q <= t_s3.b;
			end else begin
				unique case (sec_s3)
					3'd1: begin r_q <= qc; g_q <= vc; b_q <= pc; end
					3'd2: begin r_q <= pc; g_q <= vc; b_q <= tc; end
					3'd3: begin r_q <= pc; g_q <= qc; b_q <= vc; end
					3'd4: begin r_q <= tc; g_q <= pc; b_q <= vc; end
					3'd5: begin r_q <= vc; g_q <= pc; b_q <= qc; end
					default: begin r_q <= vc; g_q <= tc; b_q <= pc; end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= v_div[DLAT-1]; v_s2 <= v_s1; v_s3 <= v_s2; out_v_q <= v_s3;
		end
	end
	assign v_s4 = out_v_q;

	logic unused;
	assign unused = tag_o[0] ^ (|hq[23:17]) ^ (|sq[23:17])
		^ (|sf_s2[33]) ^ (|sfn_s2[33]) ^ p_s3[33] ^ q_s3[33] ^ tt_s3[33]
		^ fn[17] ^ (|vb_div[20:17]) ^ (|vb_prod[32:0]) ^ (|h_s1[18:16]);

	assign valid = v_s4;
	assign red_out = r_q;
	assign green_out = g_q;
	assign blue_out = b_q;
	assign frame_end_out = fe_q;
endmodule

### sim/hsv_pixel_brightness_adjust_tb.sv
`timescale 1ns / 1ps
// testbench for the hsv brightness adjust block: directed table, random pixels, self-checking
module hsv_pixel_brightness_adjust_tb
	import hsvba_pkg::*;
();

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       fe;
	} pixel_t;

	typedef struct {
		pixel_t pix;
		bit     fixed;
		pixel_t want;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       valid = 1'b0;
	logic       ready;
	logic [7:0] red_in = '0;
	logic [7:0] green_in = '0;
	logic [7:0] blue_in = '0;
	logic       frame_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       frame_end_out;
	logic       cfg_we = 1'b0;
	logic       cfg_idx = REG_BRIGHTNESS;
	logic [9:0] cfg_data = '0;

	logic [9:0] bright_pct = BRIGHT_RESET;
	logic       grey_mode = 1'b0;
	pixel_t     pending_pixels[$];
	int         errors = 0;
	int         n_sent = 0;
	int         n_recv = 0;
	int         n_frames = 0;
	longint     cycles = 0;
	bit         sending_done = 0;
	row_t       dir_rows[$];

	hsv_pixel_brightness_adjust i_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout at %0t", $time);
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] to_code(longint unsigned x);
		return 8'((x * 255) >> 16);
	endfunction

	function automatic pixel_t adjust_pixel(pixel_t p);
		pixel_t o;
		longint unsigned mx, mn, d, v, s, h, vb, f, pp, q, t, one;
		one = ONE_Q16;
		o = p;
		if (grey_mode) begin
			o.r = 8'((11 * p.r + 16 * p.g + 5 * p.b) >> 5);
			o.g = o.r;
			o.b = o.r;
			return o;
		end
		mx = p.r; mn = p.r;
		if (p.g > mx) mx = p.g;
		if (p.b > mx) mx = p.b;
		if (p.g < mn) mn = p.g;
		if (p.b < mn) mn = p.b;
		if (mx == mn) return o;
		d = mx - mn;
		v = (mx * one + 254) / 255;
		s = (d << 16) / mx;
		if (p.r == mx) begin
			if (p.g == mn) h = 5 * one + ((mx - p.b) << 16) / d;
			else h = one - ((mx - p.g) << 16) / d;
		end else if (p.g == mx) begin
			if (p.b == mn) h = one + ((mx - p.r) << 16) / d;
			else h = 3 * one - ((mx - p.b) << 16) / d;
		end else begin
			if (p.r == mn) h = 3 * one + ((mx - p.g) << 16) / d;
			else h = 5 * one - ((mx - p.r) << 16) / d;
		end
		vb = (v * bright_pct) / 100;
		if (vb > one) vb = one;
		f = h & 16'hFFFF;
		pp = (vb * (one - s)) >> 16;
		q = (vb * (one - ((s * f) >> 16))) >> 16;
		t = (vb * (one - ((s * (one - f)) >> 16))) >> 16;
		case (h >> 16)
			1: begin o.r = to_code(q); o.g = to_code(vb); o.b = to_code(pp); end
			2: begin o.r = to_code(pp); o.g = to_code(vb); o.b = to_code(t); end
			3: begin o.r = to_code(pp); o.g = to_code(q); o.b = to_code(vb); end
			4: begin o.r = to_code(t); o.g = to_code(pp); o.b = to_code(vb); end
			5: begin o.r = to_code(vb); o.g = to_code(pp); o.b = to_code(q); end
			default: begin o.r = to_code(vb); o.g = to_code(t); o.b = to_code(pp); end
		endcase
		return o;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [9:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BRIGHTNESS) bright_pct = val;
		else grey_mode = val[0];
		@(posedge clk);
	endtask

	task automatic send_pixel(pixel_t p);
		int gap;
		gap = $urandom_range(0, 6);
		if (n_sent % 200 < 40) gap = 0;
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		valid <= 1'b1;
		red_in <= p.r;
		green_in <= p.g;
		blue_in <= p.b;
		frame_end <= p.fe;
		pending_pixels.push_back(adjust_pixel(p));
		do @(posedge clk); while (!ready);
		n_sent++;
	endtask

	task automatic drain();
		valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic pixel_t mk(int r, int g, int b, int fe);
		pixel_t p;
		p.r = 8'(r); p.g = 8'(g); p.b = 8'(b); p.fe = 1'(fe);
		return p;
	endfunction

	task automatic add_row(pixel_t p, bit fixed, pixel_t want);
		row_t rw;
		rw.pix = p; rw.fixed = fixed; rw.want = want;
		dir_rows.push_back(rw);
	endtask

	// output side: random stalls, compare against oldest expectation
	initial begin
		int stall;
		pixel_t e;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 6);
			if (n_recv % 200 < 40) stall = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			n_recv++;
			if (pending_pixels.size() == 0) begin
				$display("%0t unexpected transfer r=%0d g=%0d b=%0d", $time,
					red_out, green_out, blue_out);
				errors++;
			end else begin
				e = pending_pixels.pop_front();
				if (e.fe) n_frames++;
				if ({red_out, green_out, blue_out, frame_end_out} !== {e.r, e.g, e.b, e.fe}) begin
					$display("%0t mismatch exp r=%0d g=%0d b=%0d fe=%0d act r=%0d g=%0d b=%0d fe=%0d",
						$time, e.r, e.g, e.b, e.fe, red_out, green_out, blue_out,
						frame_end_out);
					errors++;
				end
			end
		end
	end

	initial begin
		pixel_t p, w;
		int k;
		logic [9:0] levels[6] = '{10'd0, 10'd1, 10'd100, 10'd250, 10'd1000, 10'd1023};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, grey passthrough, primaries, hue wrap, frame end
		add_row(mk(0, 0, 0, 0), 1, mk(0, 0, 0, 0));
		add_row(mk(255, 255, 255, 1), 1, mk(255, 255, 255, 1));
		add_row(mk(77, 77, 77, 0), 1, mk(77, 77, 77, 0));
		add_row(mk(255, 0, 0, 0), 0, w);
		add_row(mk(0, 255, 0, 0), 0, w);
		add_row(mk(0, 0, 255, 0), 0, w);
		add_row(mk(255, 255, 0, 0), 0, w);
		add_row(mk(0, 255, 255, 0), 0, w);
		add_row(mk(255, 0, 255, 0), 0, w);
		add_row(mk(255, 0, 1, 0), 0, w);
		add_row(mk(200, 100, 50, 1), 0, w);
		add_row(mk(1, 0, 0, 0), 0, w);
		add_row(mk(10, 200, 120, 0), 0, w);
		add_row(mk(90, 30, 240, 0), 0, w);
		foreach (levels[i]) begin
			write_reg(REG_BRIGHTNESS, levels[i]);
			foreach (dir_rows[j]) begin
				send_pixel(dir_rows[j].pix);
				if (dir_rows[j].fixed) pending_pixels[$] = dir_rows[j].want;
			end
			drain();
		end
		write_reg(REG_GREYSCALE, 10'd1);
		send_pixel(mk(255, 255, 255, 0));
		pending_pixels[$] = mk(255, 255, 255, 0);
		send_pixel(mk(0, 0, 0, 1));
		pending_pixels[$] = mk(0, 0, 0, 1);
		send_pixel(mk(255, 0, 0, 0));
		pending_pixels[$] = mk(87, 87, 87, 0);
		drain();

		// random phases across brightness and mode settings
		for (k = 0; k < 1050; k++) begin
			if (k % 150 == 0) begin
				drain();
				write_reg(REG_GREYSCALE, 10'($urandom_range(0, 3) == 0));
				case ($urandom_range(0, 3))
					0: write_reg(REG_BRIGHTNESS, levels[$urandom_range(0, 5)]);
					1: write_reg(REG_BRIGHTNESS, 10'($urandom_range(50, 200)));
					default: write_reg(REG_BRIGHTNESS, 10'($urandom_range(0, 1023)));
				endcase
			end
			p = mk($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 31) == 0);
			if ($urandom_range(0, 15) == 0) begin
				p.g = p.r; p.b = p.r;
			end
			send_pixel(p);
		end
		drain();
		$display("sent %0d pixels, checked %0d, %0d frame ends, brightness 0..1023 and greyscale",
			n_sent, n_recv, n_frames);
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
